FILE: rtl/cle_pkg.sv
// Shared constants, codes and types of the cursor list engine.
package cle_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int WORD_BITS  = 32;

    localparam int MODE_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(LIST_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESET   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TO_END  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NOP     = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Shift command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        SH_HOLD   = 3'd0,
        SH_PUSH_R = 3'd1,
        SH_POP_R  = 3'd2,
        SH_ADV    = 3'd3,
        SH_RET    = 3'd4
    } shift_cmd_t;

endpackage

FILE: rtl/cle_cell.sv
// One cell of the chain: one slot of the left stack and one of the right stack.
module cle_cell (
    input  logic                            aclk,
    input  cle_pkg::shift_cmd_t             cmd,
    input  logic [cle_pkg::WORD_BITS-1:0]   l_from_lo,
    input  logic [cle_pkg::WORD_BITS-1:0]   l_from_hi,
    input  logic [cle_pkg::WORD_BITS-1:0]   r_from_lo,
    input  logic [cle_pkg::WORD_BITS-1:0]   r_from_hi,
    output logic [cle_pkg::WORD_BITS-1:0]   l_word,
    output logic [cle_pkg::WORD_BITS-1:0]   r_word
);

    logic [cle_pkg::WORD_BITS-1:0] l_word_reg, l_word_next;
    logic [cle_pkg::WORD_BITS-1:0] r_word_reg, r_word_next;

    // Slot 0 is the top of each stack; a push moves words away from it,
    // a pop moves them toward it.
    always_comb begin
        l_word_next = l_word_reg;
        r_word_next = r_word_reg;
        unique case (cmd)
            cle_pkg::SH_PUSH_R: begin
                r_word_next = r_from_lo;
            end
            cle_pkg::SH_POP_R: begin
                r_word_next = r_from_hi;
            end
            cle_pkg::SH_ADV: begin
                r_word_next = r_from_hi;
                l_word_next = l_from_lo;
            end
            cle_pkg::SH_RET: begin
                r_word_next = r_from_lo;
                l_word_next = l_from_hi;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        l_word_reg <= l_word_next;
        r_word_reg <= r_word_next;
    end

    assign l_word = l_word_reg;
    assign r_word = r_word_reg;

endmodule

FILE: rtl/cle_ctrl.sv
// Controller: handshakes, part sizes, multi-cycle cursor moves and the result register.
module cle_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cle_pkg::MODE_W-1:0]      s_mode,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cle_pkg::DATA_W-1:0]      m_data_out,
    output logic [cle_pkg::STATUS_W-1:0]    m_status,
    output logic [cle_pkg::CNT_W-1:0]       m_left_size,
    output logic [cle_pkg::CNT_W-1:0]       m_right_size,
    input  logic [cle_pkg::WORD_BITS-1:0]   front_word,
    output cle_pkg::shift_cmd_t             cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    localparam logic [cle_pkg::CNT_W-1:0] CNT_ONE = cle_pkg::CNT_W'(1);

    state_t state_reg, state_next;
    logic   to_end_reg, to_end_next;
    logic [cle_pkg::CNT_W-1:0] left_cnt_reg, left_cnt_next;
    logic [cle_pkg::CNT_W-1:0] right_cnt_reg, right_cnt_next;

    logic                          out_valid_reg, out_valid_next;
    logic [cle_pkg::DATA_W-1:0]    out_data_reg, out_data_next;
    logic [cle_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [cle_pkg::CNT_W-1:0]     out_left_reg, out_left_next;
    logic [cle_pkg::CNT_W-1:0]     out_right_reg, out_right_next;

    logic accept;
    logic load_out;
    logic [cle_pkg::CNT_W:0] total_cnt;

    assign s_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign total_cnt = {1'b0, left_cnt_reg} + {1'b0, right_cnt_reg};

    always_comb begin
        state_next      = state_reg;
        to_end_next     = to_end_reg;
        left_cnt_next   = left_cnt_reg;
        right_cnt_next  = right_cnt_reg;
        cmd             = cle_pkg::SH_HOLD;
        load_out        = 1'b0;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    load_out        = 1'b1;
                    out_data_next   = '0;
                    out_status_next = cle_pkg::STATUS_OK;
                    unique case (s_mode)
                        cle_pkg::MODE_INSERT: begin
                            if (total_cnt >= (cle_pkg::CNT_W + 1)'(cle_pkg::LIST_DEPTH)) begin
                                out_status_next = cle_pkg::STATUS_FULL;
                            end else begin
                                cmd            = cle_pkg::SH_PUSH_R;
                                right_cnt_next = right_cnt_reg + CNT_ONE;
                            end
                        end
                        cle_pkg::MODE_REMOVE: begin
                            if (right_cnt_reg == '0) begin
                                out_status_next = cle_pkg::STATUS_EMPTY;
                            end else begin
                                cmd            = cle_pkg::SH_POP_R;
                                out_data_next  = cle_pkg::DATA_W'(front_word);
                                right_cnt_next = right_cnt_reg - CNT_ONE;
                            end
                        end
                        cle_pkg::MODE_ADVANCE: begin
                            if (right_cnt_reg == '0) begin
                                out_status_next = cle_pkg::STATUS_EMPTY;
                            end else begin
                                cmd            = cle_pkg::SH_ADV;
                                left_cnt_next  = left_cnt_reg + CNT_ONE;
                                right_cnt_next = right_cnt_reg - CNT_ONE;
                            end
                        end
                        cle_pkg::MODE_RESET: begin
                            if (left_cnt_reg != '0) begin
                                cmd            = cle_pkg::SH_RET;
                                left_cnt_next  = left_cnt_reg - CNT_ONE;
                                right_cnt_next = right_cnt_reg + CNT_ONE;
                                if (left_cnt_reg != CNT_ONE) begin
                                    load_out    = 1'b0;
                                    to_end_next = 1'b0;
                                    state_next  = ST_SWEEP;
                                end
                            end
                        end
                        cle_pkg::MODE_TO_END: begin
                            if (right_cnt_reg != '0) begin
                                cmd            = cle_pkg::SH_ADV;
                                left_cnt_next  = left_cnt_reg + CNT_ONE;
                                right_cnt_next = right_cnt_reg - CNT_ONE;
                                if (right_cnt_reg != CNT_ONE) begin
                                    load_out    = 1'b0;
                                    to_end_next = 1'b1;
                                    state_next  = ST_SWEEP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // One word crosses the cursor per cycle until the moving side is empty.
                if (to_end_reg) begin
                    cmd            = cle_pkg::SH_ADV;
                    left_cnt_next  = left_cnt_reg + CNT_ONE;
                    right_cnt_next = right_cnt_reg - CNT_ONE;
                    if (right_cnt_reg == CNT_ONE) begin
                        load_out = 1'b1;
                    end
                end else begin
                    cmd            = cle_pkg::SH_RET;
                    left_cnt_next  = left_cnt_reg - CNT_ONE;
                    right_cnt_next = right_cnt_reg + CNT_ONE;
                    if (left_cnt_reg == CNT_ONE) begin
                        load_out = 1'b1;
                    end
                end
                if (load_out) begin
                    out_data_next   = '0;
                    out_status_next = cle_pkg::STATUS_OK;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
            out_left_next  = left_cnt_next;
            out_right_next = right_cnt_next;
        end else begin
            out_data_next  = out_data_reg;
            out_left_next  = out_left_reg;
            out_right_next = out_right_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            to_end_reg    <= 1'b0;
            left_cnt_reg  <= '0;
            right_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            to_end_reg    <= to_end_next;
            left_cnt_reg  <= left_cnt_next;
            right_cnt_reg <= right_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg   <= out_data_next;
        out_status_reg <= load_out ? out_status_next : out_status_reg;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_data_out   = out_data_reg;
    assign m_status     = out_status_reg;
    assign m_left_size  = out_left_reg;
    assign m_right_size = out_right_reg;

endmodule

FILE: rtl/cursor_list_engine_core.sv
// Top level of the cursor list engine: controller plus the chain of storage cells.
//
// The block keeps a bounded list of up to 64 data words split by a cursor into a
// left part and a right part. One operation item enters on the s_ channel (s_mode,
// s_data_in) and exactly one result item leaves on the m_ channel (m_data_out,
// m_status, m_left_size, m_right_size). Both channels use valid/ready.
// Insert, remove, advance and nop finish in the cycle of acceptance; their result
// is presented from an output register on the next cycle, and a new item can be
// taken every cycle while the receiver keeps up. Reset-cursor and cursor-to-end
// move one word across the cursor per cycle, as the chain shifts a single word
// each step; no new item is taken until the move is done.
// The result register lets a new item be accepted in the same cycle that the
// previous result is taken; while a result waits and m_ready is low, no new item
// is accepted. Synchronous reset (aresetn low) empties the list, places the cursor
// at the start and drops any pending result; the stored words need no clearing.
module cursor_list_engine_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cle_pkg::MODE_W-1:0]      s_mode,
    input  logic [cle_pkg::DATA_W-1:0]      s_data_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cle_pkg::DATA_W-1:0]      m_data_out,
    output logic [cle_pkg::STATUS_W-1:0]    m_status,
    output logic [cle_pkg::CNT_W-1:0]       m_left_size,
    output logic [cle_pkg::CNT_W-1:0]       m_right_size
);

    // The list is held as two stacks that meet at the cursor. Cell k holds the
    // k-th word to the left of the cursor and the k-th word to its right, so the
    // word in front of the cursor always sits in cell 0. Each step that changes the
    // list shifts one or both stacks by one place, done by neighbor handoff.
    cle_pkg::shift_cmd_t cmd;

    logic [cle_pkg::WORD_BITS-1:0] l_word [cle_pkg::LIST_DEPTH];
    logic [cle_pkg::WORD_BITS-1:0] r_word [cle_pkg::LIST_DEPTH];
    logic [cle_pkg::WORD_BITS-1:0] r_entry;

    // A word entering the right stack comes from the input on insert and from
    // the top of the left stack when the cursor steps back.
    assign r_entry = (cmd == cle_pkg::SH_RET) ? l_word[0]
                                              : s_data_in[cle_pkg::WORD_BITS-1:0];

    cle_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_out   (m_data_out),
        .m_status     (m_status),
        .m_left_size  (m_left_size),
        .m_right_size (m_right_size),
        .front_word   (r_word[0]),
        .cmd          (cmd)
    );

    for (genvar k = 0; k < cle_pkg::LIST_DEPTH; k++) begin : g_cell
        logic [cle_pkg::WORD_BITS-1:0] l_lo, l_hi, r_lo, r_hi;

        if (k == 0) begin : g_first
            assign l_lo = r_word[0];
            assign r_lo = r_entry;
        end else begin : g_inner
            assign l_lo = l_word[k-1];
            assign r_lo = r_word[k-1];
        end

        if (k == cle_pkg::LIST_DEPTH - 1) begin : g_last
            assign l_hi = '0;
            assign r_hi = '0;
        end else begin : g_body
            assign l_hi = l_word[k+1];
            assign r_hi = r_word[k+1];
        end

        cle_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .l_from_lo (l_lo),
            .l_from_hi (l_hi),
            .r_from_lo (r_lo),
            .r_from_hi (r_hi),
            .l_word    (l_word[k]),
            .r_word    (r_word[k])
        );
    end

endmodule
